### rtl/ptc_pkg.sv
// Shared constants and types for the pressure/temperature compensation unit.
// Holds datapath widths, shift amounts, thresholds and calibration register indexes.
// No dependencies; imported by the top level, the port checker and the testbench.
package ptc_pkg;

   // calibration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSURE_SENS   = 3'd0,
      CSR_PRESSURE_OFFSET = 3'd1,
      CSR_SENS_TEMP       = 3'd2,
      CSR_OFFSET_TEMP     = 3'd3,
      CSR_REFERENCE_TEMP  = 3'd4,
      CSR_TEMP_SLOPE      = 3'd5
   } csr_index_type;

   // field widths
   localparam int RAW_W  = 24;
   localparam int OUT_W  = 32;

   // internal datapath widths
   localparam int DT_W    = 26;   // dT, signed
   localparam int PROD_W  = 43;   // dT * coefficient
   localparam int DTSQ_W  = 52;   // dT squared
   localparam int TEMP_W  = 21;   // first-order temperature, signed
   localparam int WIDE_W  = 40;   // offset and sensitivity, signed
   localparam int SQ_W    = 42;   // (t - 2000)^2 and (t + 1500)^2
   localparam int NUM_W   = 48;   // offset/sensitivity correction numerators
   localparam int NUMT_W  = 56;   // temperature correction numerator
   localparam int SPLIT_W = 20;   // low slice of sensitivity for the split multiply
   localparam int PPLO_W  = 46;
   localparam int PPHI_W  = 45;
   localparam int FULL_W  = 66;
   localparam int P0_W    = 45;
   localparam int DIFF_W  = 47;

   // shift amounts
   localparam int REF_SHIFT    = 8;
   localparam int T_SHIFT      = 23;
   localparam int OFF_SHIFT    = 6;
   localparam int SENS_SHIFT   = 7;
   localparam int C1_SHIFT     = 16;
   localparam int C2_SHIFT     = 17;
   localparam int DTSQ_SHIFT   = 31;
   localparam int P0_SHIFT     = 21;
   localparam int P_SHIFT      = 15;

   // thresholds in hundredths of a degree
   localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 21'sd2000;
   localparam logic signed [TEMP_W-1:0] COLD_LIMIT = -21'sd1500;

endpackage

### rtl/pressure_temperature_compensation_unit.sv
// Pressure/temperature compensation: nine-stage pipeline from raw ADC pair to
// compensated temperature and pressure. Depends on ptc_pkg.
//
// Usage
//   Input channel (req_): one transaction carries a raw pressure and a raw
//   temperature reading. Result channel (rsp_): one transaction carries the
//   compensated temperature and pressure in hundredths, two's complement.
//   Calibration words are written through csr_write/csr_index/csr_data while
//   no transaction is in flight; indexes past the last word are ignored.
// Throughput
//   One transaction per cycle is sustained while rsp_stall does not hold a
//   result, set by the multiplier stages that each take a new operand set
//   every cycle; the 40 x 24 pressure product is split over two stages.
// Reset
//   Synchronous reset empties the pipeline and clears all calibration words.
// Back-pressure
//   While a result is held with rsp_stall high the whole pipeline freezes and
//   req_stall is raised; nothing is dropped or repeated. A waiting result that
//   is taken in the same cycle lets a new input transaction in.
module pressure_temperature_compensation_unit (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ptc_pkg::RAW_W-1:0]        req_raw_pressure,
   input  logic [ptc_pkg::RAW_W-1:0]        req_raw_temperature,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ptc_pkg::OUT_W-1:0] rsp_temperature_centi,
   output logic signed [ptc_pkg::OUT_W-1:0] rsp_pressure_centi,
   // calibration port
   input  logic                             csr_write,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ptc_pkg::*;

   // calibration words
   logic [CSR_DATA_W-1:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   // pipeline control
   logic       advance;
   logic [8:1] valid_ff;

   // stage 1: dT
   logic signed [DT_W-1:0]   dt_s1_ff, dt_in;
   logic [RAW_W-1:0]         d1_s1_ff;
   // stage 2: products with dT
   logic signed [PROD_W-1:0] prod_t_s2_ff, prod_t_in;
   logic signed [PROD_W-1:0] prod_o_s2_ff, prod_o_in;
   logic signed [PROD_W-1:0] prod_s_s2_ff, prod_s_in;
   logic signed [DTSQ_W-1:0] dtsq_s2_ff, dtsq_in;
   logic [RAW_W-1:0]         d1_s2_ff;
   // stage 3: first-order results
   logic signed [TEMP_W-1:0] t_s3_ff, t_in;
   logic signed [WIDE_W-1:0] off_s3_ff, off_in;
   logic signed [WIDE_W-1:0] sens_s3_ff, sens_in;
   logic signed [DTSQ_W-1:0] dtsq_s3_ff;
   logic [RAW_W-1:0]         d1_s3_ff;
   // stage 4: squares and range flags
   logic signed [TEMP_W-1:0] dev_a, dev_b;
   logic signed [SQ_W-1:0]   sq_a_s4_ff, sq_a_in;
   logic signed [SQ_W-1:0]   sq_b_s4_ff, sq_b_in;
   logic                     cold_s4_ff, cold_in;
   logic                     frigid_s4_ff, frigid_in;
   logic signed [TEMP_W-1:0] t_s4_ff;
   logic signed [WIDE_W-1:0] off_s4_ff, sens_s4_ff;
   logic signed [DTSQ_W-1:0] dtsq_s4_ff;
   logic [RAW_W-1:0]         d1_s4_ff;
   // stage 5: correction numerators
   logic signed [NUM_W-1:0]  sq_a_ext, sq_b_ext;
   logic signed [NUM_W-1:0]  corr_off, corr_sens;
   logic signed [NUMT_W-1:0] num_t_s5_ff, num_t_in;
   logic signed [NUM_W-1:0]  num_off_s5_ff, num_off_in;
   logic signed [NUM_W-1:0]  num_sens_s5_ff, num_sens_in;
   logic                     cold_s5_ff;
   logic signed [TEMP_W-1:0] t_s5_ff;
   logic signed [WIDE_W-1:0] off_s5_ff, sens_s5_ff;
   logic [RAW_W-1:0]         d1_s5_ff;
   // stage 6: truncation and selection
   logic signed [NUMT_W-1:0] bias_t, tq_full;
   logic signed [NUM_W-1:0]  bias_off, bias_sens, offq_full, sensq_full;
   logic signed [OUT_W-1:0]  t_s6_ff, t_c_in;
   logic signed [WIDE_W-1:0] off_s6_ff, off_c_in;
   logic signed [WIDE_W-1:0] sens_s6_ff, sens_c_in;
   logic [RAW_W-1:0]         d1_s6_ff;
   // stage 7: split pressure product
   logic signed [PPLO_W-1:0] pp_lo_s7_ff, pp_lo_in;
   logic signed [PPHI_W-1:0] pp_hi_s7_ff, pp_hi_in;
   logic signed [OUT_W-1:0]  t_s7_ff;
   logic signed [WIDE_W-1:0] off_s7_ff;
   // stage 8: recombined product
   logic signed [FULL_W-1:0] full_prod;
   logic signed [P0_W-1:0]   p0_s8_ff, p0_in;
   logic signed [OUT_W-1:0]  t_s8_ff;
   logic signed [WIDE_W-1:0] off_s8_ff;
   // stage 9: output register
   logic signed [DIFF_W-1:0] diff;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_t_ff, rsp_p_ff;

   // calibration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PRESSURE_SENS:   c1_ff <= csr_data;
            CSR_PRESSURE_OFFSET: c2_ff <= csr_data;
            CSR_SENS_TEMP:       c3_ff <= csr_data;
            CSR_OFFSET_TEMP:     c4_ff <= csr_data;
            CSR_REFERENCE_TEMP:  c5_ff <= csr_data;
            CSR_TEMP_SLOPE:      c6_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline freezes only when the held result is stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[7:1], req_valid};
         rsp_valid_ff <= valid_ff[8];
      end
   end

   // stage 1: dT = D2 - C5 * 256
   assign dt_in = $signed({2'b00, req_raw_temperature})
                - $signed({2'b00, c5_ff, {REF_SHIFT{1'b0}}});

   // stage 2: dT products
   always_comb begin
      prod_t_in = dt_s1_ff * $signed({1'b0, c6_ff});
      prod_o_in = dt_s1_ff * $signed({1'b0, c4_ff});
      prod_s_in = dt_s1_ff * $signed({1'b0, c3_ff});
      dtsq_in   = dt_s1_ff * dt_s1_ff;
   end

   // stage 3: first-order temperature, offset and sensitivity
   always_comb begin
      t_in    = TEMP_W'(prod_t_s2_ff >>> T_SHIFT) + TEMP_BASE;
      off_in  = WIDE_W'(prod_o_s2_ff >>> OFF_SHIFT)
              + $signed({7'b0, c2_ff, {C2_SHIFT{1'b0}}});
      sens_in = WIDE_W'(prod_s_s2_ff >>> SENS_SHIFT)
              + $signed({8'b0, c1_ff, {C1_SHIFT{1'b0}}});
   end

   // stage 4: squared deviations from the two thresholds
   always_comb begin
      dev_a     = t_s3_ff - TEMP_BASE;
      dev_b     = t_s3_ff - COLD_LIMIT;
      sq_a_in   = dev_a * dev_a;
      sq_b_in   = dev_b * dev_b;
      cold_in   = t_s3_ff < TEMP_BASE;
      frigid_in = t_s3_ff < COLD_LIMIT;
   end

   // stage 5: numerators of the second-order corrections
   always_comb begin
      sq_a_ext    = NUM_W'(sq_a_s4_ff);
      sq_b_ext    = frigid_s4_ff ? NUM_W'(sq_b_s4_ff) : '0;
      // 5*s + 14*s2 and 5*s + 22*s2 by shift and add
      corr_off    = (sq_a_ext <<< 2) + sq_a_ext + (sq_b_ext <<< 4) - (sq_b_ext <<< 1);
      corr_sens   = (sq_a_ext <<< 2) + sq_a_ext + (sq_b_ext <<< 4) + (sq_b_ext <<< 2)
                  + (sq_b_ext <<< 1);
      num_off_in  = (NUM_W'(off_s4_ff) <<< 1) - corr_off;
      num_sens_in = (NUM_W'(sens_s4_ff) <<< 2) - corr_sens;
      num_t_in    = (NUMT_W'(t_s4_ff) <<< DTSQ_SHIFT) - NUMT_W'(dtsq_s4_ff);
   end

   // stage 6: divide toward zero, then pick corrected or first-order values
   always_comb begin
      bias_t     = num_t_s5_ff[NUMT_W-1]   ? NUMT_W'({DTSQ_SHIFT{1'b1}}) : '0;
      bias_off   = num_off_s5_ff[NUM_W-1]  ? NUM_W'(1)                   : '0;
      bias_sens  = num_sens_s5_ff[NUM_W-1] ? NUM_W'(3)                   : '0;
      tq_full    = (num_t_s5_ff + bias_t) >>> DTSQ_SHIFT;
      offq_full  = (num_off_s5_ff + bias_off) >>> 1;
      sensq_full = (num_sens_s5_ff + bias_sens) >>> 2;
      if (cold_s5_ff) begin
         t_c_in    = OUT_W'(tq_full);
         off_c_in  = WIDE_W'(offq_full);
         sens_c_in = WIDE_W'(sensq_full);
      end else begin
         t_c_in    = OUT_W'(t_s5_ff);
         off_c_in  = off_s5_ff;
         sens_c_in = sens_s5_ff;
      end
   end

   // stage 7: sensitivity times D1 as two partial products
   always_comb begin
      pp_lo_in = $signed({1'b0, sens_s6_ff[SPLIT_W-1:0]}) * $signed({1'b0, d1_s6_ff});
      pp_hi_in = $signed(sens_s6_ff[WIDE_W-1:SPLIT_W]) * $signed({1'b0, d1_s6_ff});
   end

   // stage 8: recombine and scale
   always_comb begin
      full_prod = (FULL_W'(pp_hi_s7_ff) <<< SPLIT_W) + FULL_W'(pp_lo_s7_ff);
      p0_in     = P0_W'(full_prod >>> P0_SHIFT);
   end

   // stage 9: subtract offset and scale to hundredths
   assign diff = DIFF_W'(p0_s8_ff) - DIFF_W'(off_s8_ff);

   // datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         dt_s1_ff       <= dt_in;
         d1_s1_ff       <= req_raw_pressure;

         prod_t_s2_ff   <= prod_t_in;
         prod_o_s2_ff   <= prod_o_in;
         prod_s_s2_ff   <= prod_s_in;
         dtsq_s2_ff     <= dtsq_in;
         d1_s2_ff       <= d1_s1_ff;

         t_s3_ff        <= t_in;
         off_s3_ff      <= off_in;
         sens_s3_ff     <= sens_in;
         dtsq_s3_ff     <= dtsq_s2_ff;
         d1_s3_ff       <= d1_s2_ff;

         sq_a_s4_ff     <= sq_a_in;
         sq_b_s4_ff     <= sq_b_in;
         cold_s4_ff     <= cold_in;
         frigid_s4_ff   <= frigid_in;
         t_s4_ff        <= t_s3_ff;
         off_s4_ff      <= off_s3_ff;
         sens_s4_ff     <= sens_s3_ff;
         dtsq_s4_ff     <= dtsq_s3_ff;
         d1_s4_ff       <= d1_s3_ff;

         num_t_s5_ff    <= num_t_in;
         num_off_s5_ff  <= num_off_in;
         num_sens_s5_ff <= num_sens_in;
         cold_s5_ff     <= cold_s4_ff;
         t_s5_ff        <= t_s4_ff;
         off_s5_ff      <= off_s4_ff;
         sens_s5_ff     <= sens_s4_ff;
         d1_s5_ff       <= d1_s4_ff;

         t_s6_ff        <= t_c_in;
         off_s6_ff      <= off_c_in;
         sens_s6_ff     <= sens_c_in;
         d1_s6_ff       <= d1_s5_ff;

         pp_lo_s7_ff    <= pp_lo_in;
         pp_hi_s7_ff    <= pp_hi_in;
         t_s7_ff        <= t_s6_ff;
         off_s7_ff      <= off_s6_ff;

         p0_s8_ff       <= p0_in;
         t_s8_ff        <= t_s7_ff;
         off_s8_ff      <= off_s7_ff;

         rsp_t_ff       <= t_s8_ff;
         rsp_p_ff       <= diff[DIFF_W-1:P_SHIFT];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_t_ff;
   assign rsp_pressure_centi    = rsp_p_ff;

endmodule

### rtl/ptc_checker.sv
// Port-level checks for the pressure/temperature compensation unit.
// Depends on ptc_pkg; bound to pressure_temperature_compensation_unit below.
module ptc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [ptc_pkg::OUT_W-1:0] rsp_temperature_centi,
   input logic signed [ptc_pkg::OUT_W-1:0] rsp_pressure_centi
);
   import ptc_pkg::*;

   // a stalled result stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_temperature_centi)
                                    && $stable(rsp_pressure_centi)))
      else $error("stalled result changed or dropped");

   // back-pressure is raised exactly when the held result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output blocking");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // a result needs a transaction accepted and carried through every stage;
   // with no stall and no input while the pipeline empties, the output must be idle
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) ##1 (!req_valid && !rsp_stall) ##1
      (!req_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result appeared without a matching input transaction");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_temperature_centi (rsp_temperature_centi),
   .rsp_pressure_centi    (rsp_pressure_centi)
);

### test/pressure_temperature_compensation_unit_tb.sv
// Self-checking testbench for the pressure/temperature compensation unit.
// Drives raw ADC pairs under several calibration sets with random idling on both sides.
// Depends on ptc_pkg and the unit's RTL; expected readings come from an in-bench predictor.
module pressure_temperature_compensation_unit_tb;
   import ptc_pkg::*;

   localparam int     PERIOD         = 10;
   localparam int     PIPE_DEPTH     = 9;
   localparam int     CYCLE_LIMIT    = 200000;
   localparam int     IDLE_PERCENT   = 17;
   localparam int     HOLD_CYCLES    = 150;
   localparam int     RANDOM_PER_SET = 190;
   localparam int     NUM_COEFFS     = 6;
   localparam longint WARM_CENTI     = 2000;
   localparam longint COLD_CENTI     = -1500;

   localparam logic [RAW_W-1:0]      RAW_MAX    = '1;
   localparam logic [RAW_W-1:0]      RAW_MID    = 24'h800000;
   localparam logic [CSR_DATA_W-1:0] COEFF_MAX  = '1;
   localparam logic [CSR_IDX_W-1:0]  CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] pressure_centi;
   } compensated_type;

   // Scoreboard: calibration copy, compensation predictor and queue of awaited readings
   class compensation_scoreboard_type;
      logic [CSR_DATA_W-1:0] calib [NUM_COEFFS];
      compensated_type       awaited [$];
      int                    errors;

      function new();
         foreach (calib[i]) calib[i] = '0;
         errors = 0;
      endfunction

      function void set_coeff(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         // indexes past the last word are dropped by the unit
         if (idx < NUM_COEFFS) calib[idx] = value;
      endfunction

      function longint toward_zero(longint x, int n);
         return (x >= 0) ? (x >>> n) : -((-x) >>> n);
      endfunction

      function compensated_type compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
         longint          d1, d2, k1, k2, k3, k4, k5, k6;
         longint          dt, t, off, sens, sq, sq_cold, t_new, p0, p;
         compensated_type r;
         d1 = raw_p;
         d2 = raw_t;
         k1 = calib[CSR_PRESSURE_SENS];
         k2 = calib[CSR_PRESSURE_OFFSET];
         k3 = calib[CSR_SENS_TEMP];
         k4 = calib[CSR_OFFSET_TEMP];
         k5 = calib[CSR_REFERENCE_TEMP];
         k6 = calib[CSR_TEMP_SLOPE];
         // first order; >>> on a signed longint rounds toward minus infinity
         dt   = d2 - (k5 <<< REF_SHIFT);
         t    = WARM_CENTI + ((dt * k6) >>> T_SHIFT);
         off  = (k2 <<< C2_SHIFT) + ((dt * k4) >>> OFF_SHIFT);
         sens = (k1 <<< C1_SHIFT) + ((dt * k3) >>> SENS_SHIFT);
         // second order below 20.00 C, extra terms below -15.00 C; squares use uncorrected t
         if (t < WARM_CENTI) begin
            sq      = (t - WARM_CENTI) * (t - WARM_CENTI);
            sq_cold = 0;
            if (t < COLD_CENTI) sq_cold = (t - COLD_CENTI) * (t - COLD_CENTI);
            t_new = toward_zero((t <<< DTSQ_SHIFT) - dt * dt, DTSQ_SHIFT);
            off   = toward_zero(2 * off - 5 * sq - 14 * sq_cold, 1);
            sens  = toward_zero(4 * sens - 5 * sq - 22 * sq_cold, 2);
            t     = t_new;
         end
         p0 = (sens * d1) >>> P0_SHIFT;
         p  = (p0 - off) >>> P_SHIFT;
         r.temperature_centi = t[OUT_W-1:0];
         r.pressure_centi    = p[OUT_W-1:0];
         return r;
      endfunction

      function void note_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
         awaited.push_back(compensate(raw_p, raw_t));
      endfunction

      function void check_result(logic signed [OUT_W-1:0] temp, logic signed [OUT_W-1:0] pres);
         compensated_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result: temperature_centi %0d, pressure_centi %0d", temp, pres);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (temp !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, actual %0d", want.temperature_centi, temp);
            errors++;
         end
         if (pres !== want.pressure_centi) begin
            $error("pressure_centi: expected %0d, actual %0d", want.pressure_centi, pres);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [RAW_W-1:0]             req_raw_pressure;
   logic [RAW_W-1:0]             req_raw_temperature;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [OUT_W-1:0]      rsp_temperature_centi;
   logic signed [OUT_W-1:0]      rsp_pressure_centi;
   logic                         csr_write;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   bit                           gaps_on;
   bit                           hold_request;
   int                           cycle_count;
   compensation_scoreboard_type  sb = new();

   pressure_temperature_compensation_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_pressure      (req_raw_pressure),
      .req_raw_temperature   (req_raw_temperature),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_centi    (rsp_pressure_centi),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Calibration write; called at a falling edge, lands on the next rising edge
   task automatic write_calib(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      sb.set_coeff(idx, value);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic load_calibration(logic [CSR_DATA_W-1:0] c1, logic [CSR_DATA_W-1:0] c2,
                                   logic [CSR_DATA_W-1:0] c3, logic [CSR_DATA_W-1:0] c4,
                                   logic [CSR_DATA_W-1:0] c5, logic [CSR_DATA_W-1:0] c6);
      write_calib(CSR_PRESSURE_SENS, c1);
      write_calib(CSR_PRESSURE_OFFSET, c2);
      write_calib(CSR_SENS_TEMP, c3);
      write_calib(CSR_OFFSET_TEMP, c4);
      write_calib(CSR_REFERENCE_TEMP, c5);
      write_calib(CSR_TEMP_SLOPE, c6);
   endtask

   // One input transaction, with random idle cycles in front of it
   task automatic send_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_raw_pressure    = raw_p;
      req_raw_temperature = raw_t;
      do @(posedge clock); while (req_stall);
      sb.note_reading(raw_p, raw_t);
      @(negedge clock);
      // withdrawn until the next call offers a new pair
      req_valid = 1'b0;
   endtask

   // Raw temperature that lands first-order t on the target, clamped to the ADC range
   function automatic logic [RAW_W-1:0] raw_temp_for(longint target);
      longint slope, want, dt, d2;
      slope = sb.calib[CSR_TEMP_SLOPE];
      d2    = sb.calib[CSR_REFERENCE_TEMP];
      d2    = d2 <<< REF_SHIFT;
      if (slope != 0) begin
         want = target - WARM_CENTI;
         dt   = (want <<< T_SHIFT) / slope;
         while (((dt * slope) >>> T_SHIFT) < want) dt++;
         while (((dt * slope) >>> T_SHIFT) > want) dt--;
         d2 += dt;
      end
      if (d2 < 0) d2 = 0;
      else if (d2 > longint'(RAW_MAX)) d2 = RAW_MAX;
      return d2[RAW_W-1:0];
   endfunction

   // Random pair: mostly temperatures near the reference so all three regions are hit
   task automatic send_random_reading();
      logic [RAW_W-1:0] raw_p, raw_t;
      longint           span, dt, d2;
      if ($urandom_range(0, 7) == 0) raw_p = $urandom_range(0, 1) ? RAW_MAX : '0;
      else raw_p = $urandom_range(0, RAW_MAX);
      if ($urandom_range(0, 9) < 4) begin
         raw_t = $urandom_range(0, RAW_MAX);
      end else begin
         span = longint'(1) <<< (12 + 4 * $urandom_range(0, 3));
         dt   = $urandom_range(0, 2 * span);
         dt  -= span;
         d2   = sb.calib[CSR_REFERENCE_TEMP];
         d2   = (d2 <<< REF_SHIFT) + dt;
         if (d2 < 0) d2 = 0;
         else if (d2 > longint'(RAW_MAX)) d2 = RAW_MAX;
         raw_t = d2[RAW_W-1:0];
      end
      send_reading(raw_p, raw_t);
   endtask

   task automatic random_phase(bit with_hold);
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
         if (with_hold && n == RANDOM_PER_SET / 3) hold_request = 1'b1;
         send_random_reading();
      end
   endtask

   // Wait until every awaited reading is back, then let the pipeline settle
   task automatic drain();
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = gaps_on && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Result transactions
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_temperature_centi, rsp_pressure_centi);
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Main sequence
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      csr_write           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      gaps_on             = 1'b1;
      hold_request        = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // calibration still at its reset value
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      drain();

      // directed: ADC extremes and the 20.00 C / -15.00 C boundaries
      load_calibration(16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
      write_calib(CSR_UNUSED, COEFF_MAX);
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(24'hAAAAAA, 24'h555555);
      send_reading(24'h555555, 24'hAAAAAA);
      send_reading(RAW_MID, raw_temp_for(WARM_CENTI));
      send_reading(RAW_MID, raw_temp_for(WARM_CENTI - 1));
      send_reading(RAW_MID, raw_temp_for(COLD_CENTI));
      send_reading(RAW_MID, raw_temp_for(COLD_CENTI - 1));
      send_reading(RAW_MAX, raw_temp_for(COLD_CENTI - 1));
      send_reading(RAW_MID, raw_temp_for(4000));
      send_reading(RAW_MID, raw_temp_for(-4000));
      drain();

      // random readings under several calibration sets
      random_phase(1'b0);
      drain();

      load_calibration($urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX),
                       $urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX),
                       $urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX));
      random_phase(1'b1);
      drain();

      // all words at their top value, back to back with no idling
      gaps_on = 1'b0;
      load_calibration(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
      random_phase(1'b0);
      drain();
      gaps_on = 1'b1;

      load_calibration('0, '0, '0, '0, '0, '0);
      random_phase(1'b0);
      drain();

      load_calibration($urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX),
                       $urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX),
                       $urandom_range(0, COEFF_MAX), $urandom_range(0, COEFF_MAX));
      random_phase(1'b0);
      drain();

      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### pressure_temperature_compensation_unit.f
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation_unit.sv
rtl/ptc_checker.sv
test/pressure_temperature_compensation_unit_tb.sv
